FILE: design/gefr_pkg.sv
package gefr_pkg;

	// field widths
	localparam int unsigned SPEED_W = 16;
	localparam int unsigned SCALE_W = 24;
	localparam int unsigned RATIO_W = 16;
	localparam int unsigned GEAR_W = 3;
	localparam int unsigned STATUS_W = 2;
	localparam int unsigned INDEX_W = 3;
	localparam int unsigned GEAR_COUNT = 6;

	// one divider cell per quotient bit
	localparam int unsigned DIV_CELLS = RATIO_W;
	localparam int unsigned PROD_W = SPEED_W + SCALE_W;

	// register indexes of the configuration port
	typedef enum logic [INDEX_W-1:0] {
		REG_SCALE = 3'd0,
		REG_GEAR1 = 3'd1,
		REG_GEAR2 = 3'd2,
		REG_GEAR3 = 3'd3,
		REG_GEAR4 = 3'd4,
		REG_GEAR5 = 3'd5,
		REG_GEAR6 = 3'd6,
		REG_TOL = 3'd7
	} reg_index_t;

	// result status codes
	typedef enum logic [STATUS_W-1:0] {
		ST_MATCH = 2'd0,
		ST_ZERO = 2'd1,
		ST_REJECT = 2'd2
	} status_t;

	typedef logic [RATIO_W-1:0] ratio_t;

	// register reset values
	localparam logic [SCALE_W-1:0] SCALE_RESET = 24'd189580;
	localparam ratio_t GEAR1_RESET = 16'd14918;
	localparam ratio_t GEAR2_RESET = 16'd8520;
	localparam ratio_t GEAR3_RESET = 16'd5575;
	localparam ratio_t GEAR4_RESET = 16'd4190;
	localparam ratio_t GEAR5_RESET = 16'd3396;
	localparam ratio_t GEAR6_RESET = 16'd2810;
	localparam ratio_t TOL_RESET = 16'd1024;

	// data handed from one divider cell to the next
	typedef struct packed {
		logic [SPEED_W-1:0] rem;
		logic [RATIO_W-1:0] dvd;
		logic [RATIO_W-1:0] quo;
		logic [SPEED_W-1:0] spd;
		logic zero;
		logic sat;
	} div_t;

endpackage

FILE: design/gefr_div_cell.sv
module gefr_div_cell
	import gefr_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic en,
	input logic valid_in,
	input div_t data_in,
	output logic valid_q,
	output div_t data_q
);

	logic [SPEED_W:0] trial;
	logic ge;
	div_t nxt;

	// one restoring step: shift in the next dividend bit, subtract if it fits
	always_comb begin
		trial = {data_in.rem, data_in.dvd[RATIO_W-1]};
		ge = (trial >= {1'b0, data_in.spd});
		nxt = data_in;
		nxt.rem = ge ? SPEED_W'(trial - {1'b0, data_in.spd}) : trial[SPEED_W-1:0];
		nxt.dvd = {data_in.dvd[RATIO_W-2:0], 1'b0};
		nxt.quo = {data_in.quo[RATIO_W-2:0], ge};
	end

	// valid bit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (en) begin
			valid_q <= valid_in;
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (en) begin
			data_q <= nxt;
		end
	end

endmodule

FILE: design/gefr_match.sv
module gefr_match
	import gefr_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic en,
	input logic valid_in,
	input ratio_t ratio_in,
	input logic zero_in,
	input ratio_t [GEAR_COUNT-1:0] gear_ratio,
	input ratio_t tolerance,
	output logic valid_q,
	output logic [GEAR_W-1:0] gear_q,
	output status_t status_q,
	output ratio_t ratio_q
);

	logic valid_s1;
	logic zero_s1;
	ratio_t ratio_s1;
	ratio_t [GEAR_COUNT-1:0] diff_s1;
	ratio_t [GEAR_COUNT-1:0] diff;

	ratio_t best_diff;
	logic [GEAR_W-1:0] best_idx;
	logic [GEAR_W-1:0] gear_d;
	status_t status_d;

	// distance to every gear
	always_comb begin
		for (int i = 0; i < GEAR_COUNT; i++) begin
			diff[i] = (ratio_in >= gear_ratio[i]) ? ratio_in - gear_ratio[i]
				: gear_ratio[i] - ratio_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= valid_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			diff_s1 <= diff;
			ratio_s1 <= ratio_in;
			zero_s1 <= zero_in;
		end
	end

	// nearest gear, lower gear wins ties
	always_comb begin
		best_diff = diff_s1[0];
		best_idx = '0;
		for (int i = 1; i < GEAR_COUNT; i++) begin
			if (diff_s1[i] < best_diff) begin
				best_diff = diff_s1[i];
				best_idx = GEAR_W'(i);
			end
		end
	end

	// classify the item
	always_comb begin
		if (zero_s1) begin
			gear_d = '0;
			status_d = ST_ZERO;
		end else if (best_diff > tolerance) begin
			gear_d = '0;
			status_d = ST_REJECT;
		end else begin
			gear_d = best_idx + GEAR_W'(1);
			status_d = ST_MATCH;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (en) begin
			valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			gear_q <= gear_d;
			status_q <= status_d;
			ratio_q <= ratio_s1;
		end
	end

endmodule

FILE: design/gear_estimate_from_ratio_core.sv
// Gear estimator: engine speed and road speed in, gear, status and ratio out.
// Sample channel: sample_valid/sample_stall with engine_speed and road_speed;
// an item is taken at an edge with sample_valid high and sample_stall low.
// Result channel: result_valid/result_stall with gear, status and
// measured_ratio; the receiver holds result_stall high to keep the item.
// Configuration: cfg_valid/cfg_ready with cfg_index and cfg_data, always
// ready; write only while no items are in flight.
// From acceptance to result_valid an item passes one multiply stage, one
// prepare stage, a chain of 16 divider cells giving one quotient bit each,
// and two match stages ending in the output register. Throughput is one item
// per cycle while the chain is not held; every stage moves in lockstep.
// While result_valid is high and result_stall is high, the whole chain
// holds and sample_stall is raised; bubbles do not cause stalls otherwise.
// Reset clears all valid bits and loads the default scale, gear ratios and
// tolerance.
module gear_estimate_from_ratio_core
	import gefr_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic sample_valid,
	output logic sample_stall,
	input logic [SPEED_W-1:0] engine_speed,
	input logic [SPEED_W-1:0] road_speed,
	output logic result_valid,
	input logic result_stall,
	output logic [GEAR_W-1:0] gear,
	output logic [STATUS_W-1:0] status,
	output logic [RATIO_W-1:0] measured_ratio,
	input logic cfg_valid,
	output logic cfg_ready,
	input logic [INDEX_W-1:0] cfg_index,
	input logic [SCALE_W-1:0] cfg_data
);

	logic en;
	logic [SCALE_W-1:0] scale_q;
	ratio_t [GEAR_COUNT-1:0] gear_q;
	ratio_t tol_q;

	logic valid_s1;
	logic zero_s1;
	logic [PROD_W-1:0] prod_s1;
	logic [SPEED_W-1:0] spd_s1;

	logic [PROD_W-5:0] nsh;
	logic [PROD_W-5-RATIO_W:0] hi;
	logic valid_s2;
	div_t prep_s2;

	logic cell_valid [DIV_CELLS+1];
	div_t cell_data [DIV_CELLS+1];
	div_t last;
	ratio_t ratio_d;
	status_t status_o;

	// global advance: the chain holds only when a waiting result is stalled
	assign en = !(result_valid && result_stall);
	assign sample_stall = !en;
	assign cfg_ready = 1'b1;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scale_q <= SCALE_RESET;
			gear_q[0] <= GEAR1_RESET;
			gear_q[1] <= GEAR2_RESET;
			gear_q[2] <= GEAR3_RESET;
			gear_q[3] <= GEAR4_RESET;
			gear_q[4] <= GEAR5_RESET;
			gear_q[5] <= GEAR6_RESET;
			tol_q <= TOL_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (reg_index_t'(cfg_index))
				REG_SCALE: scale_q <= cfg_data;
				REG_GEAR1: gear_q[0] <= cfg_data[RATIO_W-1:0];
				REG_GEAR2: gear_q[1] <= cfg_data[RATIO_W-1:0];
				REG_GEAR3: gear_q[2] <= cfg_data[RATIO_W-1:0];
				REG_GEAR4: gear_q[3] <= cfg_data[RATIO_W-1:0];
				REG_GEAR5: gear_q[4] <= cfg_data[RATIO_W-1:0];
				REG_GEAR6: gear_q[5] <= cfg_data[RATIO_W-1:0];
				REG_TOL: tol_q <= cfg_data[RATIO_W-1:0];
				default: tol_q <= tol_q;
			endcase
		end
	end

	// stage 1: rpm times scale
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= sample_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			prod_s1 <= PROD_W'(engine_speed) * PROD_W'(scale_q);
			spd_s1 <= road_speed;
			zero_s1 <= (engine_speed == '0) || (road_speed == '0);
		end
	end

	// stage 2: drop the factor of 16, check for quotient overflow
	assign nsh = prod_s1[PROD_W-1:4];
	assign hi = nsh[PROD_W-5:RATIO_W];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (en) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			prep_s2.rem <= hi[SPEED_W-1:0];
			prep_s2.dvd <= nsh[RATIO_W-1:0];
			prep_s2.quo <= '0;
			prep_s2.spd <= spd_s1;
			prep_s2.zero <= zero_s1;
			prep_s2.sat <= (hi >= $bits(hi)'(spd_s1));
		end
	end

	// divider cell chain
	assign cell_valid[0] = valid_s2;
	assign cell_data[0] = prep_s2;

	for (genvar c = 0; c < DIV_CELLS; c++) begin : g_cell
		gefr_div_cell u_cell (
			.clk(clk),
			.arst_n(arst_n),
			.en(en),
			.valid_in(cell_valid[c]),
			.data_in(cell_data[c]),
			.valid_q(cell_valid[c+1]),
			.data_q(cell_data[c+1])
		);
	end

	// saturate and force zero for a stopped vehicle or engine
	assign last = cell_data[DIV_CELLS];
	always_comb begin
		if (last.zero) begin
			ratio_d = '0;
		end else if (last.sat) begin
			ratio_d = '1;
		end else begin
			ratio_d = last.quo;
		end
	end

	// gear match and output register
	gefr_match u_match (
		.clk(clk),
		.arst_n(arst_n),
		.en(en),
		.valid_in(cell_valid[DIV_CELLS]),
		.ratio_in(ratio_d),
		.zero_in(last.zero),
		.gear_ratio(gear_q),
		.tolerance(tol_q),
		.valid_q(result_valid),
		.gear_q(gear),
		.status_q(status_o),
		.ratio_q(measured_ratio)
	);

	assign status = status_o;

`ifndef SYNTHESIS
	// a match always names a real gear
	a_match_gear: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && status_o == ST_MATCH |-> gear != '0 && gear <= GEAR_W'(GEAR_COUNT))
		else $error("matched item without a valid gear");

	// a stopped item reports no gear and no ratio
	a_zero_item: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && status_o == ST_ZERO |-> gear == '0 && measured_ratio == '0)
		else $error("stopped item with gear or ratio");

	// a rejected item reports no gear
	a_reject_item: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && status_o == ST_REJECT |-> gear == '0)
		else $error("rejected item with a gear");

	// a held result stays valid and the last divider cell's valid bit does not change
	a_hold_chain: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> $stable(cell_valid[DIV_CELLS]) && result_valid)
		else $error("chain moved under a stalled result");
`endif

endmodule
